FILE: sv/dbcs_pkg.sv
package dbcs_pkg;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int CODE_W = 16;
  localparam int CHAR_W = 21;
  localparam int ST_W   = 2;

  localparam int MEM_DEPTH = 1 << CODE_W;
  localparam int SB_DEPTH  = 1 << BYTE_W;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [CHAR_W-1:0] REPL_CHAR = 21'h00FFFD;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_DECODE = 2'd1,
    OP_END    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SINGLE = 2'd1,
    ST_BAD_PAIR   = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_LOAD,
    K_SINGLE,
    K_PAIR,
    K_BAD_SINGLE,
    K_INCOMPLETE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] chr;
  } req_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

endpackage

FILE: sv/dbcs_to_unicode_decoder.sv
// double-byte code page to unicode decoder
// input channel (in_valid / in_ready) takes one request a cycle while in_ready
//   is high: in_op selects load of a table entry (in_entry_code,
//   in_entry_char), decode of one byte (in_byte) or end of stream
// output channel (out_valid / out_ready) gives out_char, out_status and
//   out_bad_lead; a lead byte waiting for its trail byte, a load and an end
//   with nothing pending give no result
// the front classifies each request against lead and single-byte valid flops,
//   a four-entry queue feeds the back, which reads the 64k table (one read and
//   one write port) and registers the result
// throughput: one request per cycle when nothing stalls, set by the single
//   table read port; requests pass the queue, stage b and output registers
// reset: the table valid flags are cleared by a sweep over all 65536 entries,
//   one entry a cycle; in_ready stays low until the sweep ends
// when the receiver stalls the result is held in the output register, the
//   queue fills and in_ready drops once it is full
module dbcs_to_unicode_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dbcs_pkg::OP_W-1:0]   in_op,
  input  logic [dbcs_pkg::BYTE_W-1:0] in_byte,
  input  logic [dbcs_pkg::CODE_W-1:0] in_entry_code,
  input  logic [dbcs_pkg::CHAR_W-1:0] in_entry_char,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dbcs_pkg::CHAR_W-1:0] out_char,
  output logic [dbcs_pkg::ST_W-1:0]   out_status,
  output logic [dbcs_pkg::BYTE_W-1:0] out_bad_lead
);
  import dbcs_pkg::*;

  qstat_t qstat;
  req_t   push_req;
  req_t   head;
  logic   push;
  logic   pop;
  logic   clr_done;

  dbcs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_byte       (in_byte),
    .in_entry_code (in_entry_code),
    .in_entry_char (in_entry_char),
    .clr_done      (clr_done),
    .qstat         (qstat),
    .push          (push),
    .push_req      (push_req)
  );

  dbcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .qstat    (qstat),
    .head     (head)
  );

  dbcs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .clr_done     (clr_done),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_status   (out_status),
    .out_bad_lead (out_bad_lead)
  );

endmodule

FILE: sv/dbcs_front.sv
module dbcs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dbcs_pkg::OP_W-1:0]   in_op,
  input  logic [dbcs_pkg::BYTE_W-1:0] in_byte,
  input  logic [dbcs_pkg::CODE_W-1:0] in_entry_code,
  input  logic [dbcs_pkg::CHAR_W-1:0] in_entry_char,
  input  logic                        clr_done,
  input  dbcs_pkg::qstat_t            qstat,
  output logic                        push,
  output dbcs_pkg::req_t              push_req
);
  import dbcs_pkg::*;

  logic [SB_DEPTH-1:0] sb_valid_r;
  logic [SB_DEPTH-1:0] lead_map_r;
  logic [BYTE_W-1:0]   pending_r;
  logic [BYTE_W-1:0]   pending_nxt;
  logic                accept;
  op_t                 op;

  assign op       = op_t'(in_op);
  assign in_ready = clr_done && !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push          = 1'b0;
    push_req.kind = K_LOAD;
    push_req.code = in_entry_code;
    push_req.chr  = in_entry_char;
    pending_nxt   = pending_r;
    if (accept) begin
      unique case (op)
        OP_LOAD: begin
          push = 1'b1;
        end
        OP_DECODE: begin
          priority if (pending_r != '0) begin
            push          = 1'b1;
            push_req.kind = K_PAIR;
            push_req.code = {pending_r, in_byte};
            pending_nxt   = '0;
          end else if (sb_valid_r[in_byte]) begin
            push          = 1'b1;
            push_req.kind = K_SINGLE;
            push_req.code = {{(CODE_W-BYTE_W){1'b0}}, in_byte};
          end else if (lead_map_r[in_byte]) begin
            pending_nxt = in_byte;
          end else begin
            push          = 1'b1;
            push_req.kind = K_BAD_SINGLE;
          end
        end
        OP_END: begin
          if (pending_r != '0) begin
            push          = 1'b1;
            push_req.kind = K_INCOMPLETE;
            push_req.code = {pending_r, {BYTE_W{1'b0}}};
            pending_nxt   = '0;
          end
        end
        OP_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= '0;
      lead_map_r <= '0;
      pending_r  <= '0;
    end else begin
      pending_r <= pending_nxt;
      if (accept && op == OP_LOAD) begin
        if (in_entry_code[CODE_W-1:BYTE_W] == '0) begin
          sb_valid_r[in_entry_code[BYTE_W-1:0]] <= 1'b1;
        end else begin
          lead_map_r[in_entry_code[CODE_W-1:BYTE_W]] <= 1'b1;
        end
      end
    end
  end

  a_pending_is_lead: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != '0 |-> lead_map_r[pending_r])
    else $error("pending byte not a lead byte");

  a_pair_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_DECODE && pending_r != '0 |-> push && push_req.kind == K_PAIR)
    else $error("pair request lost");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("request pushed without accept");

endmodule

FILE: sv/dbcs_queue.sv
module dbcs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dbcs_pkg::req_t   push_req,
  input  logic             pop,
  output dbcs_pkg::qstat_t qstat,
  output dbcs_pkg::req_t   head
);
  import dbcs_pkg::*;

  req_t           slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic [QAW:0]   count_nxt;

  assign head            = slot_r[rd_ptr_r];
  assign qstat.not_empty = count_r != '0;
  assign qstat.full      = count_r == (QAW+1)'(QDEPTH);

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: sv/dbcs_back.sv
module dbcs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dbcs_pkg::qstat_t            qstat,
  input  dbcs_pkg::req_t              head,
  output logic                        pop,
  output logic                        clr_done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dbcs_pkg::CHAR_W-1:0] out_char,
  output logic [dbcs_pkg::ST_W-1:0]   out_status,
  output logic [dbcs_pkg::BYTE_W-1:0] out_bad_lead
);
  import dbcs_pkg::*;

  // table word: valid flag over the character
  logic [CHAR_W:0]   tbl [MEM_DEPTH];
  logic [CODE_W:0]   clr_cnt_r;

  logic              b_valid_r;
  req_t              b_req_r;
  logic [CHAR_W:0]   mem_q_r;
  logic              fwd_hit_r;
  logic [CHAR_W:0]   fwd_data_r;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  status_t           out_status_r;
  logic [BYTE_W-1:0] out_bad_lead_r;

  logic [CHAR_W:0]   eff;
  logic              eff_valid;
  logic [CHAR_W-1:0] eff_char;
  logic              b_has_res;
  logic              out_free;
  logic              b_adv;
  logic              wr_en;
  logic [CODE_W-1:0] wr_addr;
  logic [CHAR_W:0]   wr_data;
  logic [CHAR_W-1:0] res_char;
  status_t           res_status;
  logic [BYTE_W-1:0] res_lead;

  assign clr_done  = clr_cnt_r[CODE_W];
  assign eff       = fwd_hit_r ? fwd_data_r : mem_q_r;
  assign eff_valid = eff[CHAR_W];
  assign eff_char  = eff[CHAR_W-1:0];
  assign b_has_res = b_req_r.kind != K_LOAD;
  assign out_free  = !out_valid_r || out_ready;
  assign b_adv     = b_valid_r && (!b_has_res || out_free);
  assign pop       = qstat.not_empty && clr_done && (!b_valid_r || b_adv);

  always_comb begin
    if (clr_done) begin
      wr_en   = b_adv && b_req_r.kind == K_LOAD && !eff_valid;
      wr_addr = b_req_r.code;
      wr_data = {1'b1, b_req_r.chr};
    end else begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r[CODE_W-1:0];
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mem_q_r <= tbl[head.code];
    end
  end

  // a write leaving stage b in the same cycle as the read is not seen by it
  always_ff @(posedge clk) begin
    if (pop) begin
      b_req_r    <= head;
      fwd_hit_r  <= wr_en && wr_addr == head.code;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (!clr_done) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (pop) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    res_char   = eff_char;
    res_status = ST_OK;
    res_lead   = '0;
    unique case (b_req_r.kind)
      K_SINGLE: begin
        res_char = eff_char;
      end
      K_PAIR: begin
        if (!(eff_valid && eff_char != '0)) begin
          res_char   = REPL_CHAR;
          res_status = ST_BAD_PAIR;
          res_lead   = b_req_r.code[CODE_W-1:BYTE_W];
        end
      end
      K_BAD_SINGLE: begin
        res_char   = REPL_CHAR;
        res_status = ST_BAD_SINGLE;
      end
      K_INCOMPLETE: begin
        res_char   = REPL_CHAR;
        res_status = ST_INCOMPLETE;
        res_lead   = b_req_r.code[CODE_W-1:BYTE_W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_has_res) begin
      out_char_r     <= res_char;
      out_status_r   <= res_status;
      out_bad_lead_r <= res_lead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv && b_has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_status   = out_status_r;
  assign out_bad_lead = out_bad_lead_r;

  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> !pop && !b_valid_r)
    else $error("request issued during table clear");

  a_lead_on_pair_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_BAD_PAIR || out_status_r == ST_INCOMPLETE)
      |-> out_bad_lead_r != '0)
    else $error("pair error without lead byte");

  a_repl_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_char_r == REPL_CHAR)
    else $error("error result without replacement character");

endmodule
